/* rtl/abd_pkg.sv */
// ----------------------------------------------------------------------------
// Archive block word decrypt package
// Shared types, constants and the mixing table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package abd_pkg;

   localparam int WORD_WIDTH   = 32;
   localparam int ADDR_WIDTH   = 8;
   localparam int TABLE_DEPTH  = 256;
   localparam int TABLE_SIZE   = 1280;
   localparam int GEN_ROUNDS   = TABLE_SIZE / TABLE_DEPTH;
   localparam int TABLE_REGION = 32'h400;

   localparam logic [WORD_WIDTH-1:0] SEED_TWO_INIT = 32'hEEEEEEEE;
   localparam logic [WORD_WIDTH-1:0] SEED_ONE_ADD  = 32'h11111111;
   localparam logic [WORD_WIDTH-1:0] SEED_TWO_ADD  = 32'd3;
   localparam int                    ROT_LEFT      = 'h15;
   localparam int                    ROT_RIGHT     = 'h0B;
   localparam int                    SEED_TWO_SHL  = 5;

   localparam logic [WORD_WIDTH-1:0] GEN_SEED    = 32'h00100001;
   localparam logic [WORD_WIDTH-1:0] GEN_MUL     = 32'd125;
   localparam logic [WORD_WIDTH-1:0] GEN_ADD     = 32'd3;
   localparam logic [WORD_WIDTH-1:0] GEN_MODULUS = 32'h002AAAAB;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [TABLE_DEPTH-1:0][WORD_WIDTH-1:0] table_type;

   typedef struct packed {
      logic load;
      logic advance;
   } pipe_ctl_type;

   function automatic word_type gen_next(input word_type s);
      return (s * GEN_MUL + GEN_ADD) % GEN_MODULUS;
   endfunction

   function automatic table_type build_mix_table();
      table_type tbl;
      word_type  s;
      word_type  hi;
      word_type  lo;
      tbl = '0;
      s   = GEN_SEED;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         for (int k = 0; k < GEN_ROUNDS; k++) begin
            s  = gen_next(s);
            hi = {s[15:0], 16'h0000};
            s  = gen_next(s);
            lo = {16'h0000, s[15:0]};
            if (i + TABLE_DEPTH * k >= TABLE_REGION) begin
               tbl[i] = hi | lo;
            end
         end
      end
      return tbl;
   endfunction

   function automatic word_type seed_one_next(input word_type s);
      return ((~s << ROT_LEFT) + SEED_ONE_ADD) | (s >> ROT_RIGHT);
   endfunction

endpackage

`default_nettype wire

/* rtl/abd_mix_rom.sv */
// ----------------------------------------------------------------------------
// Mixing table ROM
// Synchronous read-only table of 256 words with a registered read output.
// ----------------------------------------------------------------------------
`default_nettype none

module abd_mix_rom (
   input  wire                    clock,
   input  abd_pkg::pipe_ctl_type  ctl,
   input  abd_pkg::addr_type      rd_addr,
   output abd_pkg::word_type      rd_data
);
   import abd_pkg::*;

   localparam table_type MIX_TABLE = build_mix_table();

   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rd_data_ff <= MIX_TABLE[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/abd_key_sched.sv */
// ----------------------------------------------------------------------------
// First seed schedule
// Selects the first seed for each request, addresses the table and steps the
// seed for the following word.
// ----------------------------------------------------------------------------
`default_nettype none

module abd_key_sched (
   input  wire                    clock,
   input  wire                    reset,
   input  abd_pkg::pipe_ctl_type  ctl,
   input  abd_pkg::word_type      key_seed,
   input  wire                    block_start,
   output abd_pkg::addr_type      rd_addr,
   output abd_pkg::word_type      stage_seed
);
   import abd_pkg::*;

   word_type seed_one_ff;
   word_type seed_one_in;
   word_type seed_sel;
   word_type stage_seed_ff;

   assign seed_sel    = block_start ? key_seed : seed_one_ff;
   assign seed_one_in = seed_one_next(seed_sel);
   assign rd_addr     = seed_sel[ADDR_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_one_ff <= '0;
      end else if (ctl.load) begin
         seed_one_ff <= seed_one_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         stage_seed_ff <= seed_sel;
      end
   end

   assign stage_seed = stage_seed_ff;

endmodule

`default_nettype wire

/* rtl/abd_word_mix.sv */
// ----------------------------------------------------------------------------
// Word mixing stage
// Combines the table word with the second seed, produces the plain word and
// updates the second seed.
// ----------------------------------------------------------------------------
`default_nettype none

module abd_word_mix (
   input  wire                    clock,
   input  wire                    reset,
   input  abd_pkg::pipe_ctl_type  ctl,
   input  abd_pkg::word_type      cipher_word,
   input  wire                    block_start,
   input  abd_pkg::word_type      stage_seed,
   input  abd_pkg::word_type      table_word,
   output abd_pkg::word_type      plain_word
);
   import abd_pkg::*;

   word_type seed_two_ff;
   word_type seed_two_in;
   word_type cipher_ff;
   logic     start_ff;
   word_type plain_ff;
   word_type plain_in;
   word_type seed_base;
   word_type seed_sum;

   assign seed_base   = start_ff ? SEED_TWO_INIT : seed_two_ff;
   assign seed_sum    = seed_base + table_word;
   assign plain_in    = cipher_ff ^ (stage_seed + seed_sum);
   assign seed_two_in = plain_in + seed_sum + (seed_sum << SEED_TWO_SHL) + SEED_TWO_ADD;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_two_ff <= SEED_TWO_INIT;
      end else if (ctl.advance) begin
         seed_two_ff <= seed_two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cipher_ff <= cipher_word;
         start_ff  <= block_start;
      end
      if (ctl.advance) begin
         plain_ff <= plain_in;
      end
   end

   assign plain_word = plain_ff;

endmodule

`default_nettype wire

/* rtl/archive_block_word_decrypt.sv */
// ----------------------------------------------------------------------------
// Archive block word decrypt
// Decrypts archive blocks one 32-bit word per request.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    cipher_word, block_start
//   rsp      out        rsp_valid/stall    plain_word
//   csr      in         csr_valid/ready    key_seed
//
// One request is accepted per cycle while req_stall is low. The table ROM
// read is registered in the first stage, the plain word in the mixing stage.
// Reset is synchronous and loads the seeds and the key.
// While a result waits on rsp_stall, one more request is taken into the
// mixing stage before req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_block_word_decrypt (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  abd_pkg::word_type  req_cipher_word,
   input  wire                req_block_start,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output abd_pkg::word_type  rsp_plain_word,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  abd_pkg::word_type  csr_key_seed
);
   import abd_pkg::*;

   word_type     key_seed_ff;
   logic         mix_valid_ff;
   logic         mix_valid_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic         out_free;
   logic         req_accept;
   pipe_ctl_type ctl;
   addr_type     rd_addr;
   word_type     table_word;
   word_type     stage_seed;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign ctl.advance = mix_valid_ff && out_free;
   assign req_stall   = mix_valid_ff && !out_free;
   assign req_accept  = req_valid && !req_stall;
   assign ctl.load    = req_accept;

   assign mix_valid_in = req_accept || (mix_valid_ff && !ctl.advance);
   assign out_valid_in = ctl.advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         key_seed_ff  <= '0;
      end else begin
         mix_valid_ff <= mix_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            key_seed_ff <= csr_key_seed;
         end
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;

   abd_key_sched u_key_sched (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .key_seed    (key_seed_ff),
      .block_start (req_block_start),
      .rd_addr     (rd_addr),
      .stage_seed  (stage_seed)
   );

   abd_mix_rom u_mix_rom (
      .clock   (clock),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .rd_data (table_word)
   );

   abd_word_mix u_word_mix (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .cipher_word (req_cipher_word),
      .block_start (req_block_start),
      .stage_seed  (stage_seed),
      .table_word  (table_word),
      .plain_word  (rsp_plain_word)
   );

`ifndef ASSERT_OFF
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (mix_valid_ff && out_valid_ff))
      else $error("request stalled without a word in the mixing stage");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> mix_valid_ff)
      else $error("accepted request did not reach the mixing stage");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.advance |=> rsp_valid)
      else $error("mixed word did not reach the output register");

   a_start_loads_key: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_block_start) |=> (stage_seed == $past(key_seed_ff)))
      else $error("block start did not load the key into the first seed");
`endif

endmodule

`default_nettype wire
